[rtl/core/sea_pkg.sv]
// ----------------------------------------------------------------------------
// Squared error accumulator package
// Widths, operation, kind and status codes, sequencer states and the shared
// divide / square root unit's control types.
// ----------------------------------------------------------------------------
package sea_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int SUM_BITS    = 48;
  localparam int COUNT_BITS  = 24;
  localparam int AGG_BITS    = 48;
  localparam int FRAC_OUT    = 24;

  localparam int ROOT_BITS   = (SUM_BITS + FRAC_OUT + 1) / 2;
  localparam int RAD_BITS    = 2 * ROOT_BITS;
  localparam int ALU_BITS    = (COUNT_BITS + 1 > ROOT_BITS + 3) ? COUNT_BITS + 1
                                                               : ROOT_BITS + 3;
  localparam int ITER_BITS   = $clog2(SUM_BITS + 1);

  localparam int OP_BITS     = 2;
  localparam int KIND_BITS   = 2;
  localparam int STATUS_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REPORT = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

  localparam logic [KIND_BITS-1:0] KIND_MEAN_SQUARE = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_ROOT_MEAN   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_HALF_SUM    = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_INVALID     = 2'd3;

  localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_INVALID = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIVIDE,
    ST_ROOT,
    ST_RESULT
  } sea_state_t;

  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } sea_mode_t;

  typedef struct packed {
    logic      start;
    sea_mode_t mode;
  } sea_unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sea_unit_sts_t;

  function automatic logic [AGG_BITS-1:0] clamp_agg(input logic [SUM_BITS-1:0] v);
    logic [SUM_BITS+AGG_BITS-1:0] wide_v;
    logic [SUM_BITS+AGG_BITS-1:0] wide_max;
    wide_v   = (SUM_BITS + AGG_BITS)'(v);
    wide_max = {{SUM_BITS{1'b0}}, {AGG_BITS{1'b1}}};
    if (wide_v > wide_max) begin
      clamp_agg = {AGG_BITS{1'b1}};
    end else begin
      clamp_agg = wide_v[AGG_BITS-1:0];
    end
  endfunction

endpackage

[rtl/core/sea_if.sv]
// ----------------------------------------------------------------------------
// Squared error accumulator channels
// Request channel (operation and sample pair) and result channel, each with
// valid / ready and a source and a sink side.
// ----------------------------------------------------------------------------
interface sea_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [sea_pkg::OP_BITS-1:0]              operation;
  logic signed [sea_pkg::SAMPLE_BITS-1:0]   actual_value;
  logic signed [sea_pkg::SAMPLE_BITS-1:0]   ideal_value;

  modport source (output valid, output operation, output actual_value,
                  output ideal_value, input ready);
  modport sink   (input valid, input operation, input actual_value,
                  input ideal_value, output ready);
endinterface

interface sea_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [sea_pkg::DIFF_BITS-1:0]     difference;
  logic [sea_pkg::AGG_BITS-1:0]             aggregate;
  logic [sea_pkg::STATUS_BITS-1:0]          status;

  modport source (output valid, output difference, output aggregate,
                  output status, input ready);
  modport sink   (input valid, input difference, input aggregate,
                  input status, output ready);
endinterface

[rtl/core/sea_divsqrt.sv]
// ----------------------------------------------------------------------------
// Shared divide / square root unit
// Restoring divider (one quotient bit a cycle) and digit-by-digit square root
// (one root bit a cycle) over one shared compare-and-subtract.
// ----------------------------------------------------------------------------
module sea_divsqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  sea_pkg::sea_unit_ctl_t             ctl,
  input  logic [sea_pkg::SUM_BITS-1:0]       operand,
  input  logic [sea_pkg::COUNT_BITS-1:0]     divisor,
  output sea_pkg::sea_unit_sts_t             sts,
  output logic [sea_pkg::SUM_BITS-1:0]       result
);

  logic                              busy;
  logic                              done;
  sea_pkg::sea_mode_t                mode;
  logic [sea_pkg::ITER_BITS-1:0]     iter;
  logic [sea_pkg::ALU_BITS-1:0]      rem;
  logic [sea_pkg::RAD_BITS-1:0]      val;
  logic [sea_pkg::SUM_BITS-1:0]      quot;

  logic [sea_pkg::ALU_BITS-1:0]      trial_a;
  logic [sea_pkg::ALU_BITS-1:0]      trial_b;
  logic [sea_pkg::ALU_BITS:0]        trial_diff;
  logic                              fits;

  always_comb begin
    if (mode == sea_pkg::MODE_DIV) begin
      trial_a = {rem[sea_pkg::ALU_BITS-2:0], val[sea_pkg::RAD_BITS-1]};
      trial_b = {{(sea_pkg::ALU_BITS - sea_pkg::COUNT_BITS){1'b0}}, divisor};
    end else begin
      trial_a = {rem[sea_pkg::ALU_BITS-3:0], val[sea_pkg::RAD_BITS-1 -: 2]};
      trial_b = {{(sea_pkg::ALU_BITS - sea_pkg::ROOT_BITS - 2){1'b0}},
                 quot[sea_pkg::ROOT_BITS-1:0], 2'b01};
    end
    trial_diff = {1'b0, trial_a} - {1'b0, trial_b};
    fits       = !trial_diff[sea_pkg::ALU_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      mode <= sea_pkg::MODE_DIV;
      iter <= '0;
    end else begin
      done <= busy && (iter == sea_pkg::ITER_BITS'(1));
      if (ctl.start) begin
        busy <= 1'b1;
        mode <= ctl.mode;
        iter <= (ctl.mode == sea_pkg::MODE_DIV) ? sea_pkg::ITER_BITS'(sea_pkg::SUM_BITS)
                                                : sea_pkg::ITER_BITS'(sea_pkg::ROOT_BITS);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == sea_pkg::ITER_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= '0;
      quot <= '0;
      if (ctl.mode == sea_pkg::MODE_DIV) begin
        val <= {operand, {(sea_pkg::RAD_BITS - sea_pkg::SUM_BITS){1'b0}}};
      end else begin
        val <= sea_pkg::RAD_BITS'(operand) << sea_pkg::FRAC_OUT;
      end
    end else if (busy) begin
      rem  <= fits ? trial_diff[sea_pkg::ALU_BITS-1:0] : trial_a;
      quot <= {quot[sea_pkg::SUM_BITS-2:0], fits};
      if (mode == sea_pkg::MODE_DIV) begin
        val <= val << 1;
      end else begin
        val <= val << 2;
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign result   = quot;

endmodule

[rtl/core/squared_error_accumulator.sv]
// ----------------------------------------------------------------------------
// Squared error accumulator
// Accumulates squared sample differences and a sample count; reports mean
// square (integer), root mean square (12 fraction bits) or half sum of squares (integer).
// ----------------------------------------------------------------------------
//  Channel   Side   Handshake          Carries
//  req       sink   valid / ready      operation, actual_value, ideal_value
//  rsp       source valid / ready      difference, aggregate, status
//  cfg       sink   cfg_write          cfg_data -> error_kind
//
//  One request at a time. An update runs square, accumulate and result; a clear,
//  an unused code or a report without a divide goes to result; a mean square
//  report divides and a root mean square report then takes the square root, in
//  the shared one-bit-a-cycle divide / square root unit. Reset clears sum, count
//  and error_kind. A stalled result holds in the output register; a new request
//  is accepted meanwhile and waits in the result stage if it is full.
// ----------------------------------------------------------------------------
module squared_error_accumulator (
  input  logic                              clk,
  input  logic                              rst,
  sea_req_if.sink                           req,
  sea_rsp_if.source                         rsp,
  input  logic                              cfg_write,
  input  logic [sea_pkg::KIND_BITS-1:0]     cfg_data
);

  sea_pkg::sea_state_t                   state;
  sea_pkg::sea_state_t                   state_next;
  logic [sea_pkg::KIND_BITS-1:0]         error_kind;
  logic [sea_pkg::SUM_BITS-1:0]          square_sum;
  logic [sea_pkg::COUNT_BITS-1:0]        sample_count;
  logic signed [sea_pkg::DIFF_BITS-1:0]  res_diff;
  logic [sea_pkg::AGG_BITS-1:0]          res_agg;
  logic [sea_pkg::STATUS_BITS-1:0]       res_status;
  logic [sea_pkg::PROD_BITS-1:0]         product;

  logic                                  accept;
  logic                                  out_load;
  logic signed [sea_pkg::DIFF_BITS-1:0]  diff_in;
  logic [sea_pkg::DIFF_BITS-1:0]         diff_abs;
  logic [sea_pkg::SUM_BITS:0]            sum_ext;
  sea_pkg::sea_unit_ctl_t                unit_ctl;
  sea_pkg::sea_unit_sts_t                unit_sts;
  logic [sea_pkg::SUM_BITS-1:0]          unit_result;
  logic [sea_pkg::SUM_BITS-1:0]          unit_operand;

  assign accept  = req.valid && req.ready;
  assign diff_in = $signed({req.ideal_value[sea_pkg::SAMPLE_BITS-1], req.ideal_value})
                 - $signed({req.actual_value[sea_pkg::SAMPLE_BITS-1], req.actual_value});
  assign diff_abs = res_diff[sea_pkg::DIFF_BITS-1] ? sea_pkg::DIFF_BITS'(-res_diff)
                                                   : sea_pkg::DIFF_BITS'(res_diff);
  assign sum_ext  = {1'b0, square_sum} + (sea_pkg::SUM_BITS + 1)'(product);
  assign unit_operand = (state == sea_pkg::ST_IDLE) ? square_sum : unit_result;

  sea_divsqrt u_divsqrt (
    .clk     (clk),
    .rst     (rst),
    .ctl     (unit_ctl),
    .operand (unit_operand),
    .divisor (sample_count),
    .sts     (unit_sts),
    .result  (unit_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sea_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    req.ready      = 1'b0;
    out_load       = 1'b0;
    unit_ctl.start = 1'b0;
    unit_ctl.mode  = sea_pkg::MODE_DIV;
    case (state)
      sea_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          case (req.operation)
            sea_pkg::OP_UPDATE: state_next = sea_pkg::ST_SQUARE;
            sea_pkg::OP_REPORT: begin
              if (sample_count != '0 && (error_kind == sea_pkg::KIND_MEAN_SQUARE ||
                                         error_kind == sea_pkg::KIND_ROOT_MEAN)) begin
                unit_ctl.start = 1'b1;
                state_next     = sea_pkg::ST_DIVIDE;
              end else begin
                state_next = sea_pkg::ST_RESULT;
              end
            end
            default: state_next = sea_pkg::ST_RESULT;
          endcase
        end
      end
      sea_pkg::ST_SQUARE: state_next = sea_pkg::ST_ACCUM;
      sea_pkg::ST_ACCUM:  state_next = sea_pkg::ST_RESULT;
      sea_pkg::ST_DIVIDE: begin
        if (unit_sts.done) begin
          if (error_kind == sea_pkg::KIND_ROOT_MEAN) begin
            unit_ctl.start = 1'b1;
            unit_ctl.mode  = sea_pkg::MODE_SQRT;
            state_next     = sea_pkg::ST_ROOT;
          end else begin
            state_next = sea_pkg::ST_RESULT;
          end
        end
      end
      sea_pkg::ST_ROOT: begin
        if (unit_sts.done) begin
          state_next = sea_pkg::ST_RESULT;
        end
      end
      sea_pkg::ST_RESULT: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = sea_pkg::ST_IDLE;
        end
      end
      default: state_next = sea_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_kind <= sea_pkg::KIND_MEAN_SQUARE;
    end else if (cfg_write) begin
      error_kind <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (accept && req.operation == sea_pkg::OP_CLEAR) begin
      square_sum   <= '0;
      sample_count <= '0;
    end else if (state == sea_pkg::ST_ACCUM) begin
      square_sum <= sum_ext[sea_pkg::SUM_BITS] ? {sea_pkg::SUM_BITS{1'b1}}
                                               : sum_ext[sea_pkg::SUM_BITS-1:0];
      if (sample_count != {sea_pkg::COUNT_BITS{1'b1}}) begin
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_diff <= (req.operation == sea_pkg::OP_UPDATE) ? diff_in : '0;
      if (req.operation == sea_pkg::OP_REPORT && sample_count == '0) begin
        res_agg    <= '0;
        res_status <= sea_pkg::STATUS_EMPTY;
      end else if (req.operation == sea_pkg::OP_REPORT &&
                   error_kind == sea_pkg::KIND_HALF_SUM) begin
        res_agg    <= sea_pkg::clamp_agg(square_sum >> 1);
        res_status <= sea_pkg::STATUS_OK;
      end else if (req.operation == sea_pkg::OP_REPORT &&
                   error_kind == sea_pkg::KIND_INVALID) begin
        res_agg    <= '0;
        res_status <= sea_pkg::STATUS_INVALID;
      end else begin
        res_agg    <= '0;
        res_status <= sea_pkg::STATUS_OK;
      end
    end else if ((state == sea_pkg::ST_DIVIDE && unit_sts.done &&
                  error_kind != sea_pkg::KIND_ROOT_MEAN) ||
                 (state == sea_pkg::ST_ROOT && unit_sts.done)) begin
      res_agg <= sea_pkg::clamp_agg(unit_result);
    end
    if (state == sea_pkg::ST_SQUARE) begin
      product <= diff_abs[sea_pkg::SAMPLE_BITS-1:0] * diff_abs[sea_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.difference <= res_diff;
      rsp.aggregate  <= res_agg;
      rsp.status     <= res_status;
    end
  end

  a_unit_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    state == sea_pkg::ST_IDLE |-> !unit_sts.busy)
    else $error("divide / square root unit busy while accepting requests");

  a_count_after_accum: assert property (@(posedge clk) disable iff (rst)
    state == sea_pkg::ST_ACCUM |=> sample_count != '0)
    else $error("sample count zero after an update");

  a_sum_monotonic: assert property (@(posedge clk) disable iff (rst)
    state == sea_pkg::ST_ACCUM |=> square_sum >= $past(square_sum))
    else $error("square sum decreased on update");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == sea_pkg::ST_RESULT)
    else $error("result raised outside the result stage");

endmodule
